// ===== rtl/updf_pkg.sv =====
package updf_pkg;

	localparam logic [7:0]  START_BYTE_RESET = 8'd42;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;
	localparam logic [15:0] MIN_LENGTH       = 16'd4;

	typedef enum logic [1:0] {
		CFG_START_BYTE = 2'd0,
		CFG_TIMEOUT    = 2'd1,
		CFG_MAX_LENGTH = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC     = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_BADLEN  = 2'd3
	} status_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  frame_status;
		logic [15:0] frame_length;
		logic        last;
	} result_t;

endpackage

// ===== rtl/updf_in_if.sv =====
interface updf_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== rtl/updf_out_if.sv =====
interface updf_out_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  frame_status;
	logic [15:0] frame_length;
	logic        last;

	modport source (output valid, output item_kind, output payload_byte,
		output frame_status, output frame_length, output last, input ready);
	modport sink (input valid, input item_kind, input payload_byte,
		input frame_status, input frame_length, input last, output ready);
endinterface

// ===== rtl/updf_cfg_if.sv =====
interface updf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/updf_out_buf.sv =====
module updf_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  updf_pkg::result_t push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output updf_pkg::result_t pop_data
);

	updf_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/uart_packet_deframer_crc16.sv =====
// Receives UART bytes and millisecond ticks as beats on rx, one per clock at most, and
// delivers data bytes and one end-of-frame status beat per frame on result. A frame is
// the start byte, a little-endian 16-bit length that counts itself, the data and a
// CRC-16 (polynomial 0x1021, initial value zero), and the CRC residue over the body must
// be zero. Each data byte leaves two body bytes later, so the CRC bytes never appear. The
// status reports ok, CRC error, timeout or bad length; the consumer must discard the data
// of a frame whose status is not ok. Every input beat is handled in the cycle it is
// accepted and its result, if any, enters a two-entry output buffer, so rx takes a beat
// every cycle until that buffer is full. Configuration writes on cfg are always accepted
// and must be made while no frame is in progress.
module uart_packet_deframer_crc16 (
	input  logic       clk,
	input  logic       arst_n,
	updf_in_if.sink    rx,
	updf_out_if.source result,
	updf_cfg_if.sink   cfg
);

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_LEN0 = 5'b00010,
		PH_LEN1 = 5'b00100,
		PH_BODY = 5'b01000,
		PH_PEND = 5'b10000
	} phase_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = {c[7:0], c[15:8]};
		x = x ^ {8'd0, b};
		x = x ^ {12'd0, x[7:4]};
		x = x ^ {x[3:0], 12'd0};
		x = x ^ {3'd0, x[7:0], 5'd0};
		return x;
	endfunction

	logic [7:0]  start_byte_q;
	logic [15:0] timeout_q;
	logic [15:0] max_length_q;

	phase_t      phase_q, phase_d;
	logic [15:0] length_q, length_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  held0_q, held0_d;
	logic [7:0]  held1_q, held1_d;
	logic [1:0]  held_count_q, held_count_d;
	logic [15:0] idle_q, idle_d;

	logic              fire;
	logic              buf_full;
	logic              push;
	updf_pkg::result_t res;
	updf_pkg::result_t out_data;
	logic [15:0]       length_full;
	logic [15:0]       crc_next;
	logic [15:0]       remain_next;
	logic [15:0]       idle_next;
	logic              emitted;

	assign rx.ready  = !buf_full;
	assign fire      = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	assign length_full = {rx.rx_byte, length_q[7:0]};
	assign crc_next    = crc_step(crc_q, rx.rx_byte);
	assign remain_next = remain_q - 16'd1;
	assign idle_next   = idle_q + 16'd1;

	always_comb begin
		phase_d      = phase_q;
		length_d     = length_q;
		remain_d     = remain_q;
		crc_d        = crc_q;
		held0_d      = held0_q;
		held1_d      = held1_q;
		held_count_d = held_count_q;
		idle_d       = idle_q;
		push         = 1'b0;
		emitted      = 1'b0;
		res          = '0;
		if (fire) begin
			unique case (phase_q)
				PH_PEND: begin
					push             = 1'b1;
					res.item_kind    = updf_pkg::KIND_STATUS;
					res.frame_status = (crc_q != 16'd0) ? updf_pkg::ST_CRC : updf_pkg::ST_OK;
					res.frame_length = length_q;
					res.last         = 1'b1;
					phase_d          = (rx.cmd == updf_pkg::CMD_BYTE &&
						rx.rx_byte == start_byte_q) ? PH_LEN0 : PH_HUNT;
				end
				PH_LEN0: begin
					if (rx.cmd == updf_pkg::CMD_BYTE) begin
						length_d = {8'd0, rx.rx_byte};
						phase_d  = PH_LEN1;
					end
				end
				PH_LEN1: begin
					if (rx.cmd == updf_pkg::CMD_BYTE) begin
						length_d = length_full;
						if (length_full < updf_pkg::MIN_LENGTH || length_full > max_length_q) begin
							push             = 1'b1;
							res.item_kind    = updf_pkg::KIND_STATUS;
							res.frame_status = updf_pkg::ST_BADLEN;
							res.frame_length = length_full;
							res.last         = 1'b1;
							phase_d          = PH_HUNT;
						end else begin
							remain_d     = length_full - 16'd2;
							crc_d        = 16'd0;
							held_count_d = 2'd0;
							idle_d       = 16'd0;
							phase_d      = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (rx.cmd == updf_pkg::CMD_TICK) begin
						idle_d = idle_next;
						if (idle_next >= timeout_q) begin
							push             = 1'b1;
							res.item_kind    = updf_pkg::KIND_STATUS;
							res.frame_status = updf_pkg::ST_TIMEOUT;
							res.frame_length = length_q;
							res.last         = 1'b1;
							phase_d          = PH_HUNT;
						end
					end else begin
						idle_d   = 16'd0;
						crc_d    = crc_next;
						remain_d = remain_next;
						if (held_count_q == 2'd2) begin
							emitted          = 1'b1;
							push             = 1'b1;
							res.item_kind    = updf_pkg::KIND_DATA;
							res.payload_byte = held0_q;
							held0_d          = held1_q;
							held1_d          = rx.rx_byte;
						end else if (held_count_q == 2'd0) begin
							held0_d      = rx.rx_byte;
							held_count_d = 2'd1;
						end else begin
							held1_d      = rx.rx_byte;
							held_count_d = 2'd2;
						end
						if (remain_next == 16'd0) begin
							if (emitted) begin
								phase_d = PH_PEND;
							end else begin
								push             = 1'b1;
								res.item_kind    = updf_pkg::KIND_STATUS;
								res.frame_status = (crc_next != 16'd0) ?
									updf_pkg::ST_CRC : updf_pkg::ST_OK;
								res.frame_length = length_q;
								res.last         = 1'b1;
								phase_d          = PH_HUNT;
							end
						end
					end
				end
				default: begin
					if (rx.cmd == updf_pkg::CMD_BYTE && rx.rx_byte == start_byte_q) begin
						phase_d = PH_LEN0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= updf_pkg::START_BYTE_RESET;
			timeout_q    <= updf_pkg::TIMEOUT_RESET;
			max_length_q <= updf_pkg::MAX_LENGTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				updf_pkg::CFG_START_BYTE: start_byte_q <= cfg.data[7:0];
				updf_pkg::CFG_TIMEOUT:    timeout_q    <= cfg.data;
				updf_pkg::CFG_MAX_LENGTH: max_length_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			length_q     <= 16'd0;
			remain_q     <= 16'd0;
			crc_q        <= 16'd0;
			held_count_q <= 2'd0;
			idle_q       <= 16'd0;
		end else begin
			phase_q      <= phase_d;
			length_q     <= length_d;
			remain_q     <= remain_d;
			crc_q        <= crc_d;
			held_count_q <= held_count_d;
			idle_q       <= idle_d;
		end
	end

	always_ff @(posedge clk) begin
		held0_q <= held0_d;
		held1_q <= held1_d;
	end

	updf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (buf_full),
		.pop_valid (result.valid),
		.pop_ready (result.ready),
		.pop_data  (out_data)
	);

	assign result.item_kind    = out_data.item_kind;
	assign result.payload_byte = out_data.payload_byte;
	assign result.frame_status = out_data.frame_status;
	assign result.frame_length = out_data.frame_length;
	assign result.last         = out_data.last;

	// A pending status always follows a body byte that pushed out a data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PH_PEND) |-> $past(phase_q) == PH_BODY && held_count_q == 2'd2)
		else $error("status pending without a preceding body data beat");

	// While the body is open there is always at least one byte still owed.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> remain_q != 16'd0)
		else $error("body phase with no bytes remaining");

	// A status beat closes the frame: the receiver is hunting or starting a new frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && res.last |=> phase_q == PH_HUNT || phase_q == PH_LEN0)
		else $error("frame still open after its status beat");

	// The output buffer is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> !push)
		else $error("result written into a full output buffer");

endmodule

// ===== verif/uart_packet_deframer_crc16_tb.sv =====
module uart_packet_deframer_crc16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import updf_pkg::*;

	typedef enum logic [2:0] {
		HUNT_START,
		LEN_LOW,
		LEN_HIGH,
		IN_BODY,
		STATUS_DUE
	} rx_phase_t;

	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	updf_in_if  rx_if ();
	updf_out_if res_if ();
	updf_cfg_if cfg_if ();

	assign res_if.ready = sink_ready;

	uart_packet_deframer_crc16 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	result_t expected_q[$];

	int fail_count = 0;
	int result_count = 0;
	int status_count = 0;
	int live_beats = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int sink_cycle = 0;
	int stall_left = 0;

	rx_phase_t   rx_phase;
	logic [15:0] frame_len;
	logic [15:0] body_left;
	logic [15:0] frame_crc;
	logic [15:0] quiet_ticks;
	logic [7:0]  held [2];
	logic [1:0]  held_n;
	logic [7:0]  start_val;
	logic [15:0] timeout_val;
	logic [15:0] max_len_val;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
		return x;
	endfunction

	function automatic void close_frame(input status_t st);
		result_t r;
		r = '0;
		r.item_kind = KIND_STATUS;
		r.frame_status = st;
		r.frame_length = frame_len;
		r.last = 1'b1;
		expected_q.push_back(r);
	endfunction

	// Returns 0 when the beat is a tick that the receiver ignores.
	function automatic bit predict_beat(input logic cmd, input logic [7:0] b);
		result_t r;
		bit pushed_out;
		if (rx_phase == STATUS_DUE) begin
			close_frame(frame_crc != 16'h0 ? ST_CRC : ST_OK);
			rx_phase = (cmd == CMD_BYTE && b == start_val) ? LEN_LOW : HUNT_START;
			return 1'b1;
		end
		if (cmd == CMD_TICK) begin
			if (rx_phase != IN_BODY)
				return 1'b0;
			quiet_ticks = quiet_ticks + 16'd1;
			if (quiet_ticks >= timeout_val) begin
				close_frame(ST_TIMEOUT);
				rx_phase = HUNT_START;
			end
			return 1'b1;
		end
		case (rx_phase)
			LEN_LOW: begin
				frame_len = {8'h00, b};
				rx_phase = LEN_HIGH;
			end
			LEN_HIGH: begin
				frame_len[15:8] = b;
				if (frame_len < MIN_LENGTH || frame_len > max_len_val) begin
					close_frame(ST_BADLEN);
					rx_phase = HUNT_START;
				end else begin
					body_left = frame_len - 16'd2;
					frame_crc = 16'h0;
					held_n = 2'd0;
					quiet_ticks = 16'd0;
					rx_phase = IN_BODY;
				end
			end
			IN_BODY: begin
				pushed_out = 1'b0;
				quiet_ticks = 16'd0;
				frame_crc = crc16_next(frame_crc, b);
				if (held_n == 2'd2) begin
					r = '0;
					r.item_kind = KIND_DATA;
					r.payload_byte = held[0];
					expected_q.push_back(r);
					pushed_out = 1'b1;
					held[0] = held[1];
					held[1] = b;
				end else begin
					held[held_n[0]] = b;
					held_n = held_n + 2'd1;
				end
				body_left = body_left - 16'd1;
				if (body_left == 16'd0) begin
					if (pushed_out) begin
						rx_phase = STATUS_DUE;
					end else begin
						close_frame(frame_crc != 16'h0 ? ST_CRC : ST_OK);
						rx_phase = HUNT_START;
					end
				end
			end
			default: begin
				if (b == start_val)
					rx_phase = LEN_LOW;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			result_count++;
			if (expected_q.size() == 0) begin
				$error("Result beat with nothing expected: kind %0d byte %0h status %0d length %0d",
					res_if.item_kind, res_if.payload_byte, res_if.frame_status,
					res_if.frame_length);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (want.item_kind == KIND_STATUS)
					status_count++;
				check_field("item_kind", 16'(want.item_kind), 16'(res_if.item_kind));
				check_field("payload_byte", 16'(want.payload_byte), 16'(res_if.payload_byte));
				check_field("frame_status", 16'(want.frame_status), 16'(res_if.frame_status));
				check_field("frame_length", want.frame_length, res_if.frame_length);
				check_field("last", 16'(want.last), 16'(res_if.last));
			end
		end
	end

	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		case ((sink_cycle / 300) % 4)
			0: sink_ready <= 1'b1;
			1: sink_ready <= ($urandom_range(0, 9) > 2);
			2: sink_ready <= ((sink_cycle % 7) < 4);
			default: begin
				if (stall_left != 0) begin
					stall_left <= stall_left - 1;
					sink_ready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left <= $urandom_range(4, 24);
					sink_ready <= 1'b0;
				end else begin
					sink_ready <= 1'b1;
				end
			end
		endcase
	end

	task automatic send_beat(input logic cmd, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_if.valid <= 1'b1;
		rx_if.cmd <= cmd;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (rx_if.ready !== 1'b1)
			@(posedge clk);
		if (predict_beat(cmd, b))
			live_beats++;
	endtask

	task automatic send_tick();
		send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_header(input logic [15:0] len, input int tick_max);
		send_beat(CMD_BYTE, start_val);
		repeat ($urandom_range(0, tick_max)) send_tick();
		send_beat(CMD_BYTE, len[7:0]);
		repeat ($urandom_range(0, tick_max)) send_tick();
		send_beat(CMD_BYTE, len[15:8]);
	endtask

	// A negative fill gives random data bytes.
	task automatic send_frame(input int n_data, input int fill, input bit bad_crc,
		input int tick_max);
		logic [7:0] body[$];
		logic [15:0] crc;
		int pos;
		crc = 16'h0;
		for (int i = 0; i < n_data; i++) begin
			body.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
			crc = crc16_next(crc, body[i]);
		end
		body.push_back(crc[15:8]);
		body.push_back(crc[7:0]);
		if (bad_crc) begin
			pos = $urandom_range(0, body.size() - 1);
			body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		send_header(16'(n_data + 4), tick_max);
		foreach (body[i]) begin
			repeat ($urandom_range(0, tick_max)) send_tick();
			send_beat(CMD_BYTE, body[i]);
		end
	endtask

	task automatic flush_to_hunt();
		int eff;
		while (rx_phase != HUNT_START) begin
			eff = (timeout_val == 16'd0) ? 1 : int'(timeout_val);
			if (rx_phase == STATUS_DUE)
				send_tick();
			else if (rx_phase == IN_BODY && eff - int'(quiet_ticks) <= int'(body_left))
				send_tick();
			else
				send_beat(CMD_BYTE, 8'h00);
		end
	endtask

	task automatic settle();
		rx_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		flush_to_hunt();
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_START_BYTE: start_val = val[7:0];
			CFG_TIMEOUT:    timeout_val = val;
			CFG_MAX_LENGTH: max_len_val = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic test_directed_frames();
		send_tick();
		send_frame(0, -1, 1'b0, 0);
		send_frame(1, 8'hff, 1'b0, 0);
		send_frame(2, 8'h00, 1'b0, 0);
		send_tick();
		send_frame(1, 8'h5a, 1'b1, 0);
		send_header(16'd3, 0);
		send_header(16'hffff, 0);
		send_header(MAX_LENGTH_RESET + 16'd1, 0);
		send_header(16'd0, 1);
	endtask

	task automatic test_length_limits();
		write_reg(CFG_MAX_LENGTH, 16'd8);
		send_frame(4, -1, 1'b0, 0);
		send_header(16'd9, 0);
		write_reg(CFG_MAX_LENGTH, MIN_LENGTH);
		send_frame(0, -1, 1'b0, 0);
		send_header(16'd5, 0);
		write_reg(CFG_MAX_LENGTH, 16'd0);
		send_header(MIN_LENGTH, 0);
		write_reg(CFG_TIMEOUT, 16'd2);
		write_reg(CFG_MAX_LENGTH, 16'hffff);
		send_header(16'hffff, 0);
		repeat (3) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
		send_tick();
		send_tick();
		write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
		write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RESET);
	endtask

	task automatic test_timeouts();
		write_reg(CFG_TIMEOUT, 16'd1);
		send_header(16'd6, 2);
		send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
		send_tick();
		write_reg(CFG_TIMEOUT, 16'd0);
		send_header(16'd6, 0);
		send_tick();
		write_reg(CFG_TIMEOUT, 16'd3);
		send_frame(3, -1, 1'b0, 2);
		send_header(16'd8, 0);
		repeat (3) send_tick();
		write_reg(CFG_TIMEOUT, 16'hffff);
		send_frame(2, -1, 1'b0, 5);
		write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
	endtask

	task automatic test_start_byte();
		write_reg(CFG_START_BYTE, 16'h0000);
		send_beat(CMD_BYTE, START_BYTE_RESET);
		send_frame(1, 8'h00, 1'b0, 0);
		write_reg(CFG_START_BYTE, 16'h00ff);
		send_beat(CMD_BYTE, 8'h00);
		send_frame(2, 8'hff, 1'b0, 0);
		write_reg(CFG_UNUSED_INDEX, 16'hffff);
		send_frame(0, -1, 1'b0, 0);
		write_reg(CFG_START_BYTE, 16'(START_BYTE_RESET));
	endtask

	task automatic test_random_traffic();
		int target;
		int kind;
		int n_max;
		int tmax;
		int eff;
		for (int round = 0; round < 6; round++) begin
			write_reg(CFG_START_BYTE, 16'($urandom_range(0, 255)));
			if (round == 0) begin
				write_reg(CFG_TIMEOUT, 16'd1);
				write_reg(CFG_MAX_LENGTH, 16'($urandom_range(4, 24)));
			end else if (round == 4) begin
				write_reg(CFG_TIMEOUT, 16'hffff);
				write_reg(CFG_MAX_LENGTH, 16'd300);
			end else begin
				write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 12)));
				write_reg(CFG_MAX_LENGTH, 16'($urandom_range(8, 48)));
			end
			target = live_beats + 155;
			while (live_beats < target) begin
				eff = (timeout_val == 16'd0) ? 1 : int'(timeout_val);
				tmax = (eff > 8) ? 3 : eff - 1;
				n_max = int'(max_len_val) - 4;
				if (n_max > 24 && $urandom_range(0, 19) != 0)
					n_max = 24;
				kind = $urandom_range(0, 99);
				if (kind >= 85) begin
					repeat ($urandom_range(1, 8))
						send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end else begin
					flush_to_hunt();
					if (kind < 65) begin
						send_frame($urandom_range(0, n_max), -1, $urandom_range(0, 6) == 0,
							($urandom_range(0, 9) == 0) ? tmax + 2 : tmax);
					end else if (kind < 75) begin
						if ($urandom_range(0, 1) == 0 || max_len_val == 16'hffff)
							send_header(16'($urandom_range(0, 3)), 1);
						else
							send_header(16'($urandom_range(max_len_val + 1, 65535)), 1);
					end else begin
						send_header(16'($urandom_range(4, max_len_val)), 1);
						repeat ($urandom_range(0, 3))
							send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
						if (eff <= 64)
							repeat (eff) send_tick();
					end
				end
			end
		end
	endtask

	initial begin
		rx_if.valid <= 1'b0;
		rx_if.cmd <= CMD_BYTE;
		rx_if.rx_byte <= 8'h00;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_START_BYTE;
		cfg_if.data <= 16'h0000;
		rx_phase = HUNT_START;
		frame_len = 16'h0;
		body_left = 16'h0;
		frame_crc = 16'h0;
		quiet_ticks = 16'h0;
		held[0] = 8'h00;
		held[1] = 8'h00;
		held_n = 2'd0;
		start_val = START_BYTE_RESET;
		timeout_val = TIMEOUT_RESET;
		max_len_val = MAX_LENGTH_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_length_limits();
		test_timeouts();
		test_start_byte();
		test_random_traffic();
		flush_to_hunt();
		settle();
		$display("Drove %0d beats that the receiver acted on, across %0d register writes.",
			live_beats, reg_writes);
		$display("Compared %0d result beats, %0d of them end-of-frame status.",
			result_count, status_count);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(400000 * 12);
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== uart_packet_deframer_crc16.f =====
rtl/updf_pkg.sv
rtl/updf_in_if.sv
rtl/updf_out_if.sv
rtl/updf_cfg_if.sv
rtl/updf_out_buf.sv
rtl/uart_packet_deframer_crc16.sv
verif/uart_packet_deframer_crc16_tb.sv
